>>> hdl/mutual_exclusion_request_node_core_macros.svh
// Assertion macros shared by the mutual exclusion request node RTL.
`ifndef MUTUAL_EXCLUSION_REQUEST_NODE_CORE_MACROS_SVH
`define MUTUAL_EXCLUSION_REQUEST_NODE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MERQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MERQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/merq_pkg.sv
// Types and constants of the mutual exclusion request node.
package merq_pkg;

    localparam int MAX_NODES  = 16;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int STAMP_BITS = 16;
    localparam int QCNT_W     = NODE_W + 1;
    localparam int RCNT_W     = 5;
    localparam int NN_W       = 5;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_NODES = 2'd1;

    typedef enum logic [1:0] {
        FN_REQUEST = 2'd0,
        FN_REPLY   = 2'd1,
        FN_WANT    = 2'd2,
        FN_RELEASE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ACT_BCAST = 2'd0,
        ACT_REPLY = 2'd1,
        ACT_ENTER = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        NS_RELEASED = 2'd0,
        NS_WANTED   = 2'd1,
        NS_HELD     = 2'd2
    } node_state_t;

    // Outcome of one transaction, computed by the datapath.
    typedef enum logic [2:0] {
        DEC_NONE        = 3'd0,
        DEC_DEFER       = 3'd1,
        DEC_COUNT       = 3'd2,
        DEC_REPLY       = 3'd3,
        DEC_ENTER       = 3'd4,
        DEC_BCAST       = 3'd5,
        DEC_BCAST_ENTER = 3'd6,
        DEC_RELEASE     = 3'd7
    } dec_t;

    typedef struct packed {
        func_t                 func;
        logic [NODE_W-1:0]     peer_id;
        logic [STAMP_BITS-1:0] timestamp;
    } req_t;

    typedef struct packed {
        action_t               action;
        logic [NODE_W-1:0]     target_id;
        logic [STAMP_BITS-1:0] request_stamp;
        logic                  last;
    } rsp_t;

    typedef struct packed {
        logic load_in;
        logic commit;
        logic emit_enter;
        logic pop;
    } cmd_t;

    typedef struct packed {
        dec_t dec;
        logic out_free;
        logic queue_empty;
        logic queue_one;
    } sts_t;

endpackage

>>> hdl/mutual_exclusion_request_node_core.sv
// Top level of the mutual exclusion request node: controller plus datapath.
//
// One node of a distributed lock built on timestamped requests.
// Request channel (req_valid / req_stall / req_payload): peer request,
// peer reply, local want or local release. A transaction is taken at an
// edge with req_valid high and req_stall low.
// Result channel (rsp_valid / rsp_stall / rsp_payload): broadcast, reply
// or enter-critical-section results; last marks the final result of the
// request that caused them. Requests that cause nothing give no result.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0
// own_id, index 1 num_nodes; other indexes are ignored. cfg_ready is
// always high; write only while the node is idle.
// Sequence: the controller registers a transaction in idle, then decides on
// it and writes any first result to the output register, waiting while that
// register is not free; a new transaction is taken only back in idle.
// A release drains the deferred queue at one reply per cycle while the
// result channel does not stall, holding the request channel until empty.
// A stalled result register holds its payload and blocks the controller.
// Reset: node released, queue empty, own_id 0, num_nodes 1.
module mutual_exclusion_request_node_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  merq_pkg::req_t                    req_payload,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output merq_pkg::rsp_t                    rsp_payload,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [merq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [merq_pkg::NN_W-1:0]         cfg_data
);

    merq_pkg::cmd_t cmd;
    merq_pkg::sts_t sts;

    // config registers take a write in any cycle
    assign cfg_ready = 1'b1;

    merq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    merq_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_payload (req_payload),
        .cmd         (cmd),
        .sts         (sts),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_payload (rsp_payload)
    );

endmodule

>>> hdl/merq_ctrl.sv
// Controller state machine of the mutual exclusion request node.
`include "mutual_exclusion_request_node_core_macros.svh"

module merq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  merq_pkg::sts_t  sts,
    output merq_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_ENTER  = 4'b0100,
        S_DRAIN  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                // results wait for a free output register
                if (!(sts.dec inside {merq_pkg::DEC_REPLY, merq_pkg::DEC_ENTER,
                                      merq_pkg::DEC_BCAST, merq_pkg::DEC_BCAST_ENTER})
                    || sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    if (sts.dec == merq_pkg::DEC_BCAST_ENTER)
                    begin
                        state_next = S_ENTER;
                    end
                    else if (sts.dec == merq_pkg::DEC_RELEASE && !sts.queue_empty)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ENTER:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_enter = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                if (sts.out_free)
                begin
                    cmd.pop = 1'b1;
                    if (sts.queue_one)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `MERQ_ASSERT_IMPL(a_drain_nonempty, state_reg == S_DRAIN, !sts.queue_empty, "drain with empty queue")
    `MERQ_ASSERT_NEXT(a_bcast_enter, (state_reg == S_DECIDE) && cmd.commit && (sts.dec == merq_pkg::DEC_BCAST_ENTER), state_reg == S_ENTER, "enter not scheduled after broadcast")

endmodule

>>> hdl/merq_dp.sv
// Datapath of the mutual exclusion request node: node state, queue, output register.
`include "mutual_exclusion_request_node_core_macros.svh"

module merq_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr,
    input  logic [merq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [merq_pkg::NN_W-1:0]             cfg_data,
    input  merq_pkg::req_t                        req_payload,
    input  merq_pkg::cmd_t                        cmd,
    output merq_pkg::sts_t                        sts,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output merq_pkg::rsp_t                        rsp_payload
);

    localparam int NW = merq_pkg::NODE_W;
    localparam int SW = merq_pkg::STAMP_BITS;
    localparam int QW = merq_pkg::QCNT_W;
    localparam int RW = merq_pkg::RCNT_W;
    localparam logic [QW-1:0] QDEPTH = QW'(merq_pkg::MAX_NODES);

    // configuration
    logic [NW-1:0]                own_id_reg;
    logic [merq_pkg::NN_W-1:0]    num_nodes_reg;

    // protocol state
    merq_pkg::req_t               in_reg;
    merq_pkg::node_state_t        node_state_reg, node_state_next;
    logic [SW-1:0]                own_stamp_reg, own_stamp_next;
    logic [RW-1:0]                reply_count_reg, reply_count_next;
    logic [NW-1:0]                ids_reg [merq_pkg::MAX_NODES];
    logic [QW-1:0]                count_reg, count_next;
    logic [NW-1:0]                head_reg, head_next;

    // output register
    logic                         rsp_valid_reg, rsp_valid_next;
    merq_pkg::rsp_t               rsp_reg, rsp_next;

    logic [NW-1:0]                needed;
    logic [RW-1:0]                cnt_inc;
    logic                         own_first;
    logic                         q_full;
    logic [NW-1:0]                tail;
    logic                         id_we;
    merq_pkg::dec_t               dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg    <= '0;
            num_nodes_reg <= merq_pkg::NN_W'(1);
        end
        else if (cfg_wr)
        begin
            if (cfg_index == merq_pkg::CFG_OWN_ID)
            begin
                own_id_reg <= cfg_data[NW-1:0];
            end
            else if (cfg_index == merq_pkg::CFG_NUM_NODES)
            begin
                num_nodes_reg <= cfg_data;
            end
        end
    end

    // replies needed: group size clamped to 1..MAX_NODES, minus one
    always_comb
    begin
        if (num_nodes_reg == '0)
        begin
            needed = '0;
        end
        else if (num_nodes_reg > merq_pkg::NN_W'(merq_pkg::MAX_NODES))
        begin
            needed = NW'(merq_pkg::MAX_NODES - 1);
        end
        else
        begin
            needed = NW'(num_nodes_reg - merq_pkg::NN_W'(1));
        end
    end

    assign cnt_inc   = (reply_count_reg == '1) ? reply_count_reg : reply_count_reg + RW'(1);
    assign own_first = (own_stamp_reg < in_reg.timestamp) ||
                       ((own_stamp_reg == in_reg.timestamp) && (own_id_reg < in_reg.peer_id));
    assign q_full    = (count_reg >= QDEPTH);
    assign tail      = head_reg + count_reg[NW-1:0];

    always_comb
    begin
        dec = merq_pkg::DEC_NONE;
        case (in_reg.func)
            merq_pkg::FN_REQUEST:
            begin
                if (in_reg.peer_id == own_id_reg)
                begin
                    dec = merq_pkg::DEC_NONE;
                end
                else if ((node_state_reg == merq_pkg::NS_HELD ||
                          (node_state_reg == merq_pkg::NS_WANTED && own_first)) && !q_full)
                begin
                    dec = merq_pkg::DEC_DEFER;
                end
                else
                begin
                    dec = merq_pkg::DEC_REPLY;
                end
            end
            merq_pkg::FN_REPLY:
            begin
                if (in_reg.peer_id == own_id_reg || node_state_reg != merq_pkg::NS_WANTED)
                begin
                    dec = merq_pkg::DEC_NONE;
                end
                else if (cnt_inc >= RW'(needed))
                begin
                    dec = merq_pkg::DEC_ENTER;
                end
                else
                begin
                    dec = merq_pkg::DEC_COUNT;
                end
            end
            merq_pkg::FN_WANT:
            begin
                if (node_state_reg != merq_pkg::NS_RELEASED)
                begin
                    dec = merq_pkg::DEC_NONE;
                end
                else if (needed == '0)
                begin
                    dec = merq_pkg::DEC_BCAST_ENTER;
                end
                else
                begin
                    dec = merq_pkg::DEC_BCAST;
                end
            end
            merq_pkg::FN_RELEASE:
            begin
                if (node_state_reg == merq_pkg::NS_HELD)
                begin
                    dec = merq_pkg::DEC_RELEASE;
                end
            end
            default:
            begin
                dec = merq_pkg::DEC_NONE;
            end
        endcase
    end

    always_comb
    begin
        node_state_next  = node_state_reg;
        own_stamp_next   = own_stamp_reg;
        reply_count_next = reply_count_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        id_we            = 1'b0;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;

        if (cmd.commit)
        begin
            case (dec)
                merq_pkg::DEC_DEFER:
                begin
                    id_we      = 1'b1;
                    count_next = count_reg + QW'(1);
                end
                merq_pkg::DEC_COUNT:
                begin
                    reply_count_next = cnt_inc;
                end
                merq_pkg::DEC_ENTER:
                begin
                    reply_count_next = cnt_inc;
                    node_state_next  = merq_pkg::NS_HELD;
                    rsp_valid_next   = 1'b1;
                    rsp_next         = '{merq_pkg::ACT_ENTER, '0, '0, 1'b1};
                end
                merq_pkg::DEC_REPLY:
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{merq_pkg::ACT_REPLY, in_reg.peer_id, '0, 1'b1};
                end
                merq_pkg::DEC_BCAST:
                begin
                    own_stamp_next   = in_reg.timestamp;
                    node_state_next  = merq_pkg::NS_WANTED;
                    reply_count_next = '0;
                    rsp_valid_next   = 1'b1;
                    rsp_next         = '{merq_pkg::ACT_BCAST, '0, in_reg.timestamp, 1'b1};
                end
                merq_pkg::DEC_BCAST_ENTER:
                begin
                    own_stamp_next   = in_reg.timestamp;
                    node_state_next  = merq_pkg::NS_HELD;
                    reply_count_next = '0;
                    rsp_valid_next   = 1'b1;
                    rsp_next         = '{merq_pkg::ACT_BCAST, '0, in_reg.timestamp, 1'b0};
                end
                merq_pkg::DEC_RELEASE:
                begin
                    node_state_next = merq_pkg::NS_RELEASED;
                end
                default:
                begin
                    node_state_next = node_state_reg;
                end
            endcase
        end
        else if (cmd.emit_enter)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '{merq_pkg::ACT_ENTER, '0, '0, 1'b1};
        end
        else if (cmd.pop)
        begin
            head_next      = head_reg + NW'(1);
            count_next     = count_reg - QW'(1);
            rsp_valid_next = 1'b1;
            rsp_next       = '{merq_pkg::ACT_REPLY, ids_reg[head_reg], '0,
                               count_reg == QW'(1)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_state_reg  <= merq_pkg::NS_RELEASED;
            own_stamp_reg   <= '0;
            reply_count_reg <= '0;
            count_reg       <= '0;
            head_reg        <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            node_state_reg  <= node_state_next;
            own_stamp_reg   <= own_stamp_next;
            reply_count_reg <= reply_count_next;
            count_reg       <= count_next;
            head_reg        <= head_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (cmd.load_in)
        begin
            in_reg <= req_payload;
        end
        if (id_we)
        begin
            ids_reg[tail] <= in_reg.peer_id;
        end
    end

    assign sts.dec         = dec;
    assign sts.out_free    = !rsp_valid_reg || !rsp_stall;
    assign sts.queue_empty = (count_reg == '0);
    assign sts.queue_one   = (count_reg == QW'(1));

    assign rsp_valid   = rsp_valid_reg;
    assign rsp_payload = rsp_reg;

    `MERQ_ASSERT_IMPL(a_q_bound, 1'b1, count_reg <= QDEPTH, "deferred count beyond depth")
    `MERQ_ASSERT_IMPL(a_defer_room, id_we, count_reg < QDEPTH, "deferral into full queue")
    `MERQ_ASSERT_NEXT(a_pop_dec, cmd.pop, count_reg + QW'(1) == $past(count_reg), "pop did not shrink queue")

endmodule
